/* rtl/core/sphere_frustum_cull_assert.svh */
// Assertion macros for the sphere culling block.
`ifndef SPHERE_FRUSTUM_CULL_ASSERT_SVH
`define SPHERE_FRUSTUM_CULL_ASSERT_SVH
`ifndef SYNTHESIS
`define SFC_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SFC_ASSERT_RESET(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFC_ASSERT_IMPL(label, clk, rst, prop, msg)
`define SFC_ASSERT_RESET(label, clk, rst, prop, msg)
`endif
`endif

/* rtl/core/sfc_pkg.sv */
package sfc_pkg;
   localparam int NumPlanes = 6;
   localparam int NumCfg = 8;
   localparam int CoefW = 33;
   localparam int SqW = 68;
   localparam int MagW = 34;
   localparam int SqrtSteps = 34;
   localparam int DotW = 128;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [30:0] sphere_radius;
   } sphere_type;

   typedef struct packed {
      logic signed [CoefW-1:0] a;
      logic signed [CoefW-1:0] b;
      logic signed [CoefW-1:0] c;
      logic signed [CoefW-1:0] w;
   } plane_type;

   typedef struct packed {
      logic [SqW-1:0] rem;
      logic [MagW-1:0] root;
   } sqrt_type;
endpackage

/* rtl/core/sfc_if.sv */
interface sfc_req_if import sfc_pkg::*; ();
   logic valid;
   logic ready;
   sphere_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sfc_rsp_if ();
   logic valid;
   logic ready;
   logic visible;
   modport source (output valid, output visible, input ready);
   modport sink (input valid, input visible, output ready);
endinterface

/* rtl/core/sfc_sqrt_cell.sv */
// One restoring square-root step, registered.
module sfc_sqrt_cell import sfc_pkg::*; #(
   parameter int Bit = 0
) (
   input  logic     clock,
   input  logic     en,
   input  sqrt_type d_in,
   output sqrt_type d_out
);
   logic [SqW-1:0] trial;
   sqrt_type nxt_in, q_ff;

   always_comb begin
      trial = (SqW'({d_in.root, 1'b0}) | (SqW'(1) << Bit)) << Bit;
      nxt_in = d_in;
      if (d_in.rem >= trial) begin
         nxt_in.rem = d_in.rem - trial;
         nxt_in.root = d_in.root | (MagW'(1) << Bit);
      end
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= nxt_in;
   end
   assign d_out = q_ff;
endmodule

/* rtl/core/sfc_plane_cell.sv */
// Plane test: squares, chain of root cells, dot product, sign test.
module sfc_plane_cell import sfc_pkg::*; #(
   parameter int FracBits = 16
) (
   input  logic       clock,
   input  logic       en,
   input  plane_type  plane,
   input  sphere_type sph,
   output logic       cull
);
   logic [SqW-1:0] sq_in, sq_ff;
   sqrt_type chain [SqrtSteps+1];
   logic signed [DotW-1:0] px_ff, py_ff, pz_ff, w_ff;
   logic signed [DotW-1:0] dot_ff [SqrtSteps];
   logic [30:0] rad_ff [SqrtSteps+2];
   logic signed [DotW-1:0] acc_in, acc_ff;
   logic [MagW-1:0] mag_ff;
   logic zero_ff, cull_ff;

   assign sq_in = SqW'(plane.a * plane.a) + SqW'(plane.b * plane.b)
      + SqW'(plane.c * plane.c);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in;
         px_ff <= DotW'(plane.a * sph.center_x);
         py_ff <= DotW'(plane.b * sph.center_y);
         pz_ff <= DotW'(plane.c * sph.center_z);
         w_ff <= DotW'(plane.w) <<< FracBits;
      end
   end

   assign chain[0] = '{rem: sq_ff, root: '0};
   for (genvar i = 0; i < SqrtSteps; i++) begin : g_root
      sfc_sqrt_cell #(.Bit(SqrtSteps-1-i)) u_cell (
         .clock(clock), .en(en), .d_in(chain[i]), .d_out(chain[i+1]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0] <= sph.sphere_radius;
         dot_ff[0] <= px_ff + py_ff + pz_ff + w_ff;
         for (int i = 0; i < SqrtSteps - 1; i++) begin
            dot_ff[i+1] <= dot_ff[i];
         end
         for (int i = 0; i < SqrtSteps + 1; i++) begin
            rad_ff[i+1] <= rad_ff[i];
         end
         mag_ff <= chain[SqrtSteps].root;
         zero_ff <= (chain[SqrtSteps].root == '0);
         acc_ff <= dot_ff[SqrtSteps-1];
      end
   end

   assign acc_in = acc_ff + $signed(DotW'({1'b0, rad_ff[SqrtSteps+1]} * mag_ff));

   always_ff @(posedge clock) begin
      if (en) cull_ff <= !zero_ff && acc_in[DotW-1];
   end
   assign cull = cull_ff;
endmodule

/* rtl/core/sphere_frustum_cull.sv */
// Channel | Dir | Payload
// req     | in  | center_x, center_y, center_z, sphere_radius
// rsp     | out | visible
// csr     | in  | csr_we, csr_index, csr_wdata
// One sphere per cycle while the output is not stalled; the result passes through the 34-cell root chain.
// The pipeline advances whenever its last stage is empty or taken (stall-all).
// Reset is synchronous and clears the valid bits and the matrix to identity.
`include "sphere_frustum_cull_assert.svh"
module sphere_frustum_cull import sfc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   sfc_req_if.sink     req,
   sfc_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   localparam int Lat = SqrtSteps + 3;
   logic [63:0] cfg_ff [NumCfg];
   logic [Lat-1:0] vld_ff;
   logic en;
   logic [NumPlanes-1:0] cull;
   plane_type planes [NumPlanes];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[0] <= 64'd65536;
         cfg_ff[1] <= '0;
         cfg_ff[2] <= 64'd281474976710656;
         cfg_ff[3] <= '0;
         cfg_ff[4] <= '0;
         cfg_ff[5] <= 64'd65536;
         cfg_ff[6] <= '0;
         cfg_ff[7] <= 64'd281474976710656;
      end else if (csr_we) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   function automatic logic signed [CoefW-1:0] ent(logic [63:0] w, logic hi);
      logic [31:0] v;
      v = hi ? w[63:32] : w[31:0];
      return CoefW'($signed(v));
   endfunction

   always_comb begin
      for (int p = 0; p < NumPlanes; p++) begin
         logic signed [CoefW-1:0] o [4];
         logic signed [CoefW-1:0] b [4];
         logic signed [CoefW-1:0] r [4];
         for (int c = 0; c < 4; c++) begin
            b[c] = ent(cfg_ff[c*2+1], 1'b1);
            o[c] = ent(cfg_ff[c*2 + (p/2)/2], 1'((p/2)%2));
            r[c] = (p % 2 == 1) ? b[c] - o[c] : b[c] + o[c];
         end
         planes[p] = '{a: r[0], b: r[1], c: r[2], w: r[3]};
      end
   end

   assign en = !vld_ff[Lat-1] || rsp.ready;
   assign req.ready = en;

   for (genvar p = 0; p < NumPlanes; p++) begin : g_plane
      sfc_plane_cell #(.FracBits(FRAC_BITS)) u_plane (
         .clock(clock), .en(en), .plane(planes[p]), .sph(req.data), .cull(cull[p]));
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[Lat-2:0], req.valid};
   end

   assign rsp.valid = vld_ff[Lat-1];
   assign rsp.visible = (cull == '0);

   `SFC_ASSERT_IMPL(a_hold, clock, reset, rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.visible), "result changed under stall")
   `SFC_ASSERT_IMPL(a_ready, clock, reset, !rsp.valid |-> req.ready, "input blocked while output empty")
   `SFC_ASSERT_RESET(a_reset, clock, reset, reset |=> !rsp.valid, "valid after reset")
endmodule
